/* design/bpa_pkg.sv */
// bpa_pkg: shared codes for the bitmap page allocator.
// Holds command, status, operation-kind and sequencer state types.
// No dependencies.
package bpa_pkg;

  localparam int unsigned PAGE_W  = 36;
  localparam int unsigned COUNT_W = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_RESV,
    K_BAD,
    K_NOSPACE
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DIV2,
    S_RMW_RD,
    S_RMW_WR
  } state_t;

endpackage

/* design/bpa_front.sv */
// bpa_front: accepts command beats, checks them against the window and
// holds them in a two-entry queue for the back end. Uses bpa_pkg.
module bpa_front #(
  parameter int unsigned NUM_PAGES = 32768,
  parameter int unsigned PW        = $clog2(NUM_PAGES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic [bpa_pkg::PAGE_W-1:0]   first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]  page_count,
  input  logic [bpa_pkg::PAGE_W-1:0]   base_page,
  input  logic                         hold,
  output logic                         q_valid,
  output bpa_pkg::kind_t               q_kind,
  output logic [PW-1:0]                q_off,
  output logic [bpa_pkg::COUNT_W-1:0]  q_cnt,
  input  logic                         q_pop
);

  bpa_pkg::kind_t                 kind_mem_r [2];
  logic [PW-1:0]                  off_mem_r  [2];
  logic [bpa_pkg::COUNT_W-1:0]    cnt_mem_r  [2];
  logic                           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]                     fill_r, fill_nxt;
  bpa_pkg::kind_t                 kind_c;
  logic [bpa_pkg::PAGE_W-1:0]     diff_c;
  logic                           acc_c;

  assign full    = (fill_r == 2'd2) || hold;
  assign acc_c   = push && !full;
  assign q_valid = (fill_r != 2'd0);
  assign q_kind  = kind_mem_r[rp_r];
  assign q_off   = off_mem_r[rp_r];
  assign q_cnt   = cnt_mem_r[rp_r];
  assign diff_c  = first_page - base_page;

  // classify the beat: window checks happen here so the back end only executes
  always_comb begin
    kind_c = bpa_pkg::K_BAD;
    if (page_count != '0) begin
      priority if (command == bpa_pkg::CMD_ALLOC) begin
        if (32'(page_count) > 32'(NUM_PAGES)) kind_c = bpa_pkg::K_NOSPACE;
        else kind_c = bpa_pkg::K_ALLOC;
      end else if (command == bpa_pkg::CMD_FREE || command == bpa_pkg::CMD_RESERVE) begin
        if (first_page >= base_page && diff_c < bpa_pkg::PAGE_W'(NUM_PAGES) &&
            32'(page_count) + 32'(diff_c[PW-1:0]) <= 32'(NUM_PAGES)) begin
          kind_c = (command == bpa_pkg::CMD_FREE) ? bpa_pkg::K_FREE : bpa_pkg::K_RESV;
        end
      end else begin
        kind_c = bpa_pkg::K_BAD;
      end
    end
  end

  always_comb begin
    wp_nxt   = wp_r ^ acc_c;
    rp_nxt   = rp_r ^ (q_pop && q_valid);
    fill_nxt = fill_r + {1'b0, acc_c} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_c) begin
      kind_mem_r[wp_r] <= kind_c;
      off_mem_r[wp_r]  <= diff_c[PW-1:0];
      cnt_mem_r[wp_r]  <= page_count;
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill above two");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd0 && !acc_c) |=> fill_r == 2'd0)
    else $error("queue fill rose without a push");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd2 && !(q_pop && q_valid)) |=> fill_r == 2'd2)
    else $error("queue fill changed while full");

endmodule

/* design/bpa_back.sv */
// bpa_back: executes queued operations on the page bitmap memory and holds
// the result register. Scans, clears and range updates. Uses bpa_pkg.
module bpa_back #(
  parameter int unsigned NUM_PAGES = 32768,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned PW        = $clog2(NUM_PAGES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bpa_pkg::PAGE_W-1:0]   base_page,
  input  logic                         q_valid,
  input  bpa_pkg::kind_t               q_kind,
  input  logic [PW-1:0]                q_off,
  input  logic [bpa_pkg::COUNT_W-1:0]  q_cnt,
  output logic                         q_pop,
  output logic                         clr_busy,
  output logic                         res_valid,
  output logic [1:0]                   res_status,
  output logic [bpa_pkg::PAGE_W-1:0]   res_start,
  input  logic                         res_pop
);

  localparam int unsigned WC  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW  = (WC > 1) ? $clog2(WC) : 1;
  localparam int unsigned CW  = $clog2(WC + 1);
  localparam int unsigned TW  = $clog2(WORD_BITS + 1);
  localparam int unsigned BW  = $clog2(WORD_BITS);
  localparam int unsigned SH  = PW + 7;
  localparam longint unsigned RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned MW  = 2 * SH + 2;

  logic [WORD_BITS-1:0] mem [WC];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  bpa_pkg::state_t             st_r, st_nxt;
  bpa_pkg::kind_t              kind_r, kind_nxt;
  logic [CW-1:0]               a_r, a_nxt, wi_r, wi_nxt;
  logic                        dv_r, dv_nxt;
  logic [PW-1:0]               run_r, run_nxt, rs_r, rs_nxt, wb_r, wb_nxt;
  logic [PW-1:0]               off_r, off_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [bpa_pkg::COUNT_W-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [AW-1:0]               wd_r, wd_nxt;
  logic [BW-1:0]               bo_r, bo_nxt;
  logic                        set_r, set_nxt;
  logic                        rv_r, rv_nxt;
  logic [1:0]                  rst_r, rst_nxt;
  logic [bpa_pkg::PAGE_W-1:0]  rsp_r, rsp_nxt;

  logic [WORD_BITS-1:0] free_c, win_c, mask_c, lm_c;
  logic [TW-1:0]        tz_c, lz_c, jl_c, n_c, room_c;
  logic                 win_any_c;
  logic [MW-1:0]        prod_c;

  assign clr_busy   = (st_r == bpa_pkg::S_CLEAR);
  assign res_valid  = rv_r;
  assign res_status = rst_r;
  assign res_start  = rsp_r;
  assign free_c     = ~rdata_r;
  assign prod_c     = MW'(p_r) * MW'(RECIP);

  // per-word run figures: free bits at the bottom, at the top, first whole window
  always_comb begin
    tz_c = TW'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) if (!free_c[i]) tz_c = TW'(i);
    lz_c = TW'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) if (!free_c[i]) lz_c = TW'(WORD_BITS - 1 - i);
    lm_c = (32'(cnt_r) >= WORD_BITS) ? '1 : ((WORD_BITS'(1) << cnt_r) - WORD_BITS'(1));
    for (int i = 0; i < WORD_BITS; i++)
      win_c[i] = (32'(cnt_r) + i <= WORD_BITS) && (((rdata_r >> i) & lm_c) == '0);
    win_any_c = (win_c != '0);
    jl_c = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) if (win_c[i]) jl_c = TW'(i);
  end

  always_comb begin
    room_c = TW'(WORD_BITS - 32'(bo_r));
    n_c    = (32'(rem_r) < 32'(room_c)) ? TW'(rem_r) : room_c;
    for (int i = 0; i < WORD_BITS; i++)
      mask_c[i] = (i >= 32'(bo_r)) && (i < 32'(bo_r) + 32'(n_c));
  end

  always_comb begin
    st_nxt = st_r;   kind_nxt = kind_r; a_nxt = a_r;   wi_nxt = wi_r;
    dv_nxt = dv_r;   run_nxt = run_r;   rs_nxt = rs_r; wb_nxt = wb_r;
    off_nxt = off_r; p_nxt = p_r;       q_nxt = q_r;   cnt_nxt = cnt_r;
    rem_nxt = rem_r; wd_nxt = wd_r;     bo_nxt = bo_r; set_nxt = set_r;
    rv_nxt = rv_r && !res_pop; rst_nxt = rst_r; rsp_nxt = rsp_r;
    q_pop = 1'b0; mem_we = 1'b0; mem_wa = '0; mem_ra = '0; mem_wd = '1;
    unique case (st_r)
      bpa_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = a_r[AW-1:0];
        a_nxt  = a_r + CW'(1);
        if (a_r == CW'(WC - 1)) st_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (q_valid && !rv_r) begin
          q_pop    = 1'b1;
          kind_nxt = q_kind;
          cnt_nxt  = q_cnt;
          unique case (q_kind)
            bpa_pkg::K_ALLOC: begin
              st_nxt = bpa_pkg::S_SCAN;
              a_nxt = '0; wi_nxt = '0; dv_nxt = 1'b0;
              run_nxt = '0; rs_nxt = '0; wb_nxt = '0;
            end
            bpa_pkg::K_FREE, bpa_pkg::K_RESV: begin
              st_nxt  = bpa_pkg::S_DIV;
              off_nxt = q_off;
              p_nxt   = q_off;
              rem_nxt = q_cnt;
              set_nxt = (q_kind == bpa_pkg::K_RESV);
            end
            bpa_pkg::K_NOSPACE: begin
              rv_nxt = 1'b1; rst_nxt = bpa_pkg::ST_NO_SPACE; rsp_nxt = '0;
            end
            default: begin
              rv_nxt = 1'b1; rst_nxt = bpa_pkg::ST_BAD; rsp_nxt = '0;
            end
          endcase
        end
      end
      bpa_pkg::S_SCAN: begin
        // issue one read a cycle; evaluate the word that arrived last cycle
        if (32'(a_r) < WC) begin
          mem_ra = a_r[AW-1:0];
          a_nxt  = a_r + CW'(1);
          dv_nxt = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          wi_nxt = wi_r + CW'(1);
          wb_nxt = PW'(32'(wb_r) + WORD_BITS);
          priority if (32'(run_r) + 32'(tz_c) >= 32'(cnt_r)) begin
            p_nxt = (run_r != '0) ? rs_r : wb_r;
          end else if (win_any_c) begin
            p_nxt = PW'(32'(wb_r) + 32'(jl_c));
          end
          if (32'(run_r) + 32'(tz_c) >= 32'(cnt_r) || win_any_c) begin
            off_nxt = p_nxt;
            rem_nxt = cnt_r;
            set_nxt = 1'b1;
            st_nxt  = bpa_pkg::S_DIV;
          end else begin
            if (tz_c == TW'(WORD_BITS)) begin
              run_nxt = PW'(32'(run_r) + WORD_BITS);
              rs_nxt  = (run_r != '0) ? rs_r : wb_r;
            end else begin
              run_nxt = PW'(lz_c);
              rs_nxt  = PW'(32'(wb_r) + WORD_BITS - 32'(lz_c));
            end
            if (wi_r == CW'(WC - 1)) begin
              st_nxt = bpa_pkg::S_IDLE;
              rv_nxt = 1'b1; rst_nxt = bpa_pkg::ST_NO_SPACE; rsp_nxt = '0;
            end
          end
        end
      end
      bpa_pkg::S_DIV: begin
        q_nxt  = PW'(prod_c >> SH);
        st_nxt = bpa_pkg::S_DIV2;
      end
      bpa_pkg::S_DIV2: begin
        wd_nxt = q_r[AW-1:0];
        bo_nxt = BW'(32'(p_r) - 32'(q_r) * WORD_BITS);
        st_nxt = bpa_pkg::S_RMW_RD;
      end
      bpa_pkg::S_RMW_RD: begin
        mem_ra = wd_r;
        st_nxt = bpa_pkg::S_RMW_WR;
      end
      bpa_pkg::S_RMW_WR: begin
        mem_we  = 1'b1;
        mem_wa  = wd_r;
        mem_wd  = set_r ? (rdata_r | mask_c) : (rdata_r & ~mask_c);
        rem_nxt = rem_r - bpa_pkg::COUNT_W'(n_c);
        if (rem_nxt == '0) begin
          st_nxt  = bpa_pkg::S_IDLE;
          rv_nxt  = 1'b1;
          rst_nxt = bpa_pkg::ST_OK;
          rsp_nxt = (kind_r == bpa_pkg::K_ALLOC) ?
                    base_page + bpa_pkg::PAGE_W'(off_r) : '0;
        end else begin
          wd_nxt = wd_r + AW'(1);
          bo_nxt = '0;
          st_nxt = bpa_pkg::S_RMW_RD;
        end
      end
      default: st_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bpa_pkg::S_CLEAR;
      a_r  <= '0;
      dv_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      a_r  <= a_nxt;
      dv_r <= dv_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; wi_r <= wi_nxt; run_r <= run_nxt; rs_r <= rs_nxt;
    wb_r <= wb_nxt; off_r <= off_nxt; p_r <= p_nxt; q_r <= q_nxt;
    cnt_r <= cnt_nxt; rem_r <= rem_nxt; wd_r <= wd_nxt; bo_r <= bo_nxt;
    set_r <= set_nxt; rst_r <= rst_nxt; rsp_r <= rsp_nxt;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == bpa_pkg::S_IDLE && !rv_r))
    else $error("operation taken while busy or result pending");
  a_rmw_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bpa_pkg::S_RMW_WR) |-> (rem_r != '0))
    else $error("range update with nothing left");
  a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bpa_pkg::S_SCAN) |-> (32'(run_r) <= NUM_PAGES))
    else $error("free run longer than window");

endmodule

/* design/bitmap_page_allocator.sv */
// Bitmap page allocator, top level: configuration register, front end and back end.
// Depends on bpa_pkg, bpa_front and bpa_back.
//
// Keeps one used bit per page of a window of NUM_PAGES pages starting at
// cfg base page (reset 4096). Commands: allocate a first-fit run, free a
// range, reserve a range. After reset a clearing pass marks every page used,
// one bitmap word a cycle, with full held high. Bad and no-space commands pass
// from the queue straight into the result register, with no bitmap pass, when
// the back end is idle. An allocate scans the bitmap one word a cycle through
// the single memory read port until it finds a run or passes the last word. A
// range update then splits the offset into word and bit (S_DIV, S_DIV2), then
// reads and writes back each touched word in turn (S_RMW_RD, S_RMW_WR); a free
// or reserve is first taken from the queue in S_IDLE. The front queue takes
// two further commands while the back end works, and one result waits in the
// output register until popped.
module bitmap_page_allocator #(
  parameter int unsigned NUM_PAGES = 32768,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_command,
  input  logic [bpa_pkg::PAGE_W-1:0]   in_first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]  in_page_count,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   out_status,
  output logic [bpa_pkg::PAGE_W-1:0]   out_start_page,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::PAGE_W-1:0]   cfg_wdata
);

  localparam int unsigned PW = $clog2(NUM_PAGES + 1);

  logic [bpa_pkg::PAGE_W-1:0]  base_r, base_nxt;
  logic                        q_valid, q_pop, clr_busy, res_valid;
  bpa_pkg::kind_t              q_kind;
  logic [PW-1:0]               q_off;
  logic [bpa_pkg::COUNT_W-1:0] q_cnt;

  // hold the base page; the user must write it only while idle, the block does not enforce this
  assign base_nxt = cfg_we ? cfg_wdata : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= bpa_pkg::PAGE_W'(4096);
    end else begin
      base_r <= base_nxt;
    end
  end

  assign empty = !res_valid;

  bpa_front #(.NUM_PAGES(NUM_PAGES), .PW(PW)) u_front (
    .clk, .rst_n, .push, .full,
    .command(in_command), .first_page(in_first_page), .page_count(in_page_count),
    .base_page(base_r), .hold(clr_busy),
    .q_valid, .q_kind, .q_off, .q_cnt, .q_pop
  );

  bpa_back #(.NUM_PAGES(NUM_PAGES), .WORD_BITS(WORD_BITS), .PW(PW)) u_back (
    .clk, .rst_n, .base_page(base_r),
    .q_valid, .q_kind, .q_off, .q_cnt, .q_pop, .clr_busy,
    .res_valid, .res_status(out_status), .res_start(out_start_page),
    .res_pop(pop)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking bench for bitmap_page_allocator: queue-style drive of commands, a
// page-bitmap scoreboard that predicts every reply, and base page reprogramming.
// Depends on bpa_pkg and the allocator RTL.
module tb_top;

  localparam int unsigned WINDOW     = 32768;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [35:0] PAGE_MAX    = 36'hF_FFFF_FFFF;
  localparam longint      CYCLE_LIMIT = 10_000_000;
  localparam int          PHASE_ITEMS = 110;

  typedef struct packed {
    logic [1:0]  status;
    logic [35:0] start;
  } reply_t;

  // Scoreboard: holds its own page bitmap and base page, and the replies owed.
  class page_scoreboard;
    bit          page_taken[WINDOW];
    logic [35:0] base;
    reply_t      owed[$];
    int          errors;
    int          n_ok, n_nospace, n_bad, n_beats;

    function new();
      foreach (page_taken[i]) page_taken[i] = 1'b1;
      base = 36'd4096;
    endfunction

    function void set_base(logic [35:0] value);
      base = value;
    endfunction

    function void mark(int unsigned off, int unsigned cnt, bit used);
      for (int unsigned p = off; p < off + cnt; p++) page_taken[p] = used;
    endfunction

    // Work out the reply for an accepted command and update the bitmap.
    function void note_command(logic [1:0] cmd, logic [35:0] first, logic [15:0] cnt);
      reply_t      r;
      int unsigned run;
      logic [35:0] off;
      r.status = bpa_pkg::ST_BAD;
      r.start  = '0;
      run      = 0;
      if (cnt != 0 && cmd == bpa_pkg::CMD_ALLOC) begin
        r.status = bpa_pkg::ST_NO_SPACE;
        if (cnt <= WINDOW) begin
          for (int unsigned p = 0; p < WINDOW; p++) begin
            if (page_taken[p]) run = 0;
            else run++;
            if (run == cnt) begin
              mark(p + 1 - cnt, cnt, 1'b1);
              r.start  = base + 36'(p + 1 - cnt);
              r.status = bpa_pkg::ST_OK;
              break;
            end
          end
        end
      end else if (cnt != 0 && (cmd == bpa_pkg::CMD_FREE || cmd == bpa_pkg::CMD_RESERVE)) begin
        if (first >= base) begin
          off = first - base;
          if (off < WINDOW && cnt <= WINDOW - off) begin
            mark(int'(off), cnt, cmd == bpa_pkg::CMD_RESERVE);
            r.status = bpa_pkg::ST_OK;
          end
        end
      end
      case (r.status)
        bpa_pkg::ST_OK:       n_ok++;
        bpa_pkg::ST_NO_SPACE: n_nospace++;
        default:              n_bad++;
      endcase
      owed.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [35:0] start);
      reply_t e;
      n_beats++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected reply status=%0d start=%h", $time, status, start);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (status !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (start !== e.start) begin
        $display("%0t: start_page mismatch expected %h actual %h", $time, e.start, start);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        push, full, empty, pop, cfg_we;
  logic [1:0]  in_command, out_status;
  logic [35:0] in_first_page, out_start_page, cfg_wdata;
  logic [15:0] in_page_count;

  page_scoreboard sb;
  bit     calm;
  int     phases;
  longint cycles;

  bitmap_page_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_command(in_command), .in_first_page(in_first_page), .in_page_count(in_page_count),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_start_page(out_start_page),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest legal run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: stall in random bursts, take a beat whenever pop meets !empty.
  initial begin : result_side
    int stall;
    stall = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) pop = 1'b1;
      else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        pop   = 1'b0;
      end else pop = 1'b1;
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check_reply(out_status, out_start_page);
    end
  end

  // Present one command and hold it until it is accepted; an idle burst may come first.
  task automatic send_command(logic [1:0] cmd, logic [35:0] first, logic [15:0] cnt);
    if (!calm && $urandom_range(0, 6) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_command    = cmd;
    in_first_page = first;
    in_page_count = cnt;
    push          = 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_command(cmd, first, cnt);
    @(negedge clk);
  endtask

  // Drain every owed reply, then let the block settle before touching the register.
  task automatic drain();
    push = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_base(logic [35:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_base(value);
  endtask

  // Mostly well-formed commands aimed inside the window; some pure noise.
  task automatic random_command();
    logic [1:0]  cmd;
    logic [35:0] first;
    int unsigned cnt, off, pick;
    pick = $urandom_range(0, 99);
    off  = $urandom_range(0, WINDOW - 1);
    if ($urandom_range(0, 99) < 85) cnt = $urandom_range(1, 48);
    else if ($urandom_range(0, 9) < 8) cnt = $urandom_range(49, 2048);
    else cnt = $urandom_range(1, WINDOW);
    if (off + cnt > WINDOW && $urandom_range(0, 9) < 7) off = WINDOW - cnt;
    first = sb.base + 36'(off);
    if (pick < 8) begin
      cmd   = 2'($urandom);
      first = {4'($urandom), 32'($urandom)};
      cnt   = 16'($urandom);
    end else if (pick < 52) begin
      cmd   = bpa_pkg::CMD_ALLOC;
      first = {4'($urandom), 32'($urandom)};
    end else if (pick < 82) cmd = bpa_pkg::CMD_FREE;
    else cmd = bpa_pkg::CMD_RESERVE;
    send_command(cmd, first, 16'(cnt));
  endtask

  initial begin : stimulus
    logic [35:0] b;
    sb            = new();
    calm          = 1'b0;
    phases        = 0;
    push          = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_command    = bpa_pkg::CMD_ALLOC;
    in_first_page = '0;
    in_page_count = '0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every command, count and range edges at the reset base page.
    b = sb.base;
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd1);           // nothing free after reset
    send_command(bpa_pkg::CMD_FREE, b, 16'd32768);         // open the whole window
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd0);           // zero count
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd32769);       // larger than the window
    send_command(bpa_pkg::CMD_ALLOC, PAGE_MAX, 16'hFFFF);
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd1);
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd32768);
    send_command(CMD_UNKNOWN, b, 16'd5);
    send_command(bpa_pkg::CMD_FREE, b - 36'd1, 16'd1);     // below the window
    send_command(bpa_pkg::CMD_FREE, b + 36'd32767, 16'd2); // runs off the top
    send_command(bpa_pkg::CMD_FREE, b + 36'd32767, 16'd1);
    send_command(bpa_pkg::CMD_RESERVE, b, 16'd0);
    send_command(bpa_pkg::CMD_RESERVE, PAGE_MAX, 16'd1);
    send_command(bpa_pkg::CMD_FREE, '0, 16'd1);
    send_command(bpa_pkg::CMD_RESERVE, b + 36'd100, 16'd50);
    send_command(bpa_pkg::CMD_RESERVE, b + 36'd100, 16'd50); // already used
    send_command(bpa_pkg::CMD_FREE, b + 36'd100, 16'd50);
    send_command(bpa_pkg::CMD_FREE, b + 36'd100, 16'd50);    // already free
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd40);
    send_command(bpa_pkg::CMD_RESERVE, b + 36'd1, 16'd32767);
    send_command(bpa_pkg::CMD_FREE, b + 36'd32760, 16'd8);
    send_command(bpa_pkg::CMD_ALLOC, '0, 16'd8);
    send_command(bpa_pkg::CMD_FREE, b, 16'd32768);

    // Random phases under different base pages, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_base('0);
        1: write_base(PAGE_MAX - 36'd40);    // allocations wrap past the top
        2: write_base(PAGE_MAX);
        3: write_base({4'($urandom), 32'($urandom)});
        default: write_base(36'd4096);
      endcase
      phases++;
      if (ph == 1) send_command(bpa_pkg::CMD_FREE, sb.base, 16'd200);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i >= PHASE_ITEMS - 60) calm = 1'b1;
        random_command();
      end
    end

    push = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d command beats over %0d base page settings: %0d ok, %0d no space, %0d bad.",
             sb.n_beats, phases + 1, sb.n_ok, sb.n_nospace, sb.n_bad);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
